// File: rtl/gblp_pkg.sv
package gblp_pkg;

   // buffer geometry
   localparam int MaxGroupLen = 64;
   localparam int AddrW       = $clog2(MaxGroupLen);
   localparam int CountW      = $clog2(MaxGroupLen + 1);

   // arithmetic widths
   localparam int ElemW   = 24;
   localparam int GammaW  = 24;
   localparam int SumW    = 54;
   localparam int NormW   = SumW / 2;
   localparam int RadiusW = 32;
   localparam int QuoW    = ElemW;
   localparam int DvdW    = NormW + QuoW;

   // register map
   localparam int PaddrW = 3;
   localparam logic [0:0] RegGammaColumn = 1'b0;
   localparam logic [0:0] RegGammaRow    = 1'b1;
   localparam logic [GammaW-1:0] GammaReset = 24'd65536;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACC,
      ST_ROOT_GO,
      ST_ROOT,
      ST_READ,
      ST_MUL,
      ST_DIV,
      ST_EMIT
   } state_type;

   // start and done of a multi-cycle unit
   typedef struct packed {
      logic start;
      logic done;
   } unit_ctl_type;

endpackage

// File: rtl/gblp_ram.sv
module gblp_ram #(
   parameter int Width = 24,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/gblp_sqrt.sv
module gblp_sqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gblp_pkg::SumW-1:0]   radicand,
   output logic                        done,
   output logic [gblp_pkg::NormW-1:0]  root
);

   logic [gblp_pkg::SumW-1:0]    rad_ff, rad_in;
   logic [gblp_pkg::NormW+2:0]   rem_ff, rem_in;
   logic [gblp_pkg::NormW-1:0]   root_ff, root_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [gblp_pkg::NormW+2:0]   rem_sh;
   logic [gblp_pkg::NormW+2:0]   trial;

   // one result bit per cycle, restoring method
   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff[gblp_pkg::NormW:0], rad_ff[gblp_pkg::SumW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = 5'(gblp_pkg::NormW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rad_in = {rad_ff[gblp_pkg::SumW-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = rem_sh - trial;
            root_in = {root_ff[gblp_pkg::NormW-2:0], 1'b1};
         end else begin
            rem_in  = rem_sh;
            root_in = {root_ff[gblp_pkg::NormW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// File: rtl/gblp_div.sv
module gblp_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [gblp_pkg::DvdW-1:0]   dividend,
   input  logic [gblp_pkg::NormW-1:0]  divisor,
   output logic                        done,
   output logic [gblp_pkg::QuoW-1:0]   quotient
);

   logic [gblp_pkg::NormW-1:0] rem_ff, rem_in;
   logic [gblp_pkg::NormW-1:0] dvs_ff, dvs_in;
   logic [gblp_pkg::QuoW-1:0]  low_ff, low_in;
   logic [gblp_pkg::QuoW-1:0]  quo_ff, quo_in;
   logic [4:0]                 cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [gblp_pkg::NormW:0]   rem_sh;

   // quotient fits QuoW bits, so the upper dividend bits start as remainder
   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_sh  = {rem_ff, low_ff[gblp_pkg::QuoW-1]};
      if (start) begin
         rem_in  = dividend[gblp_pkg::DvdW-1 -: gblp_pkg::NormW];
         low_in  = dividend[gblp_pkg::QuoW-1:0];
         dvs_in  = divisor;
         quo_in  = '0;
         cnt_in  = 5'(gblp_pkg::QuoW - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         low_in = {low_ff[gblp_pkg::QuoW-2:0], 1'b0};
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = gblp_pkg::NormW'(rem_sh - {1'b0, dvs_ff});
            quo_in = {quo_ff[gblp_pkg::QuoW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[gblp_pkg::NormW-1:0];
            quo_in = {quo_ff[gblp_pkg::QuoW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: rtl/group_l2_ball_projection_top.sv
// channel   direction  handshake               payload
// req       in         req_valid / req_ready   elem_value, group_weight, row_group, last_in_group
// rsp       out        rsp_valid / rsp_ready   scaled_value, last_of_group, was_clipped,
//                                              group_overflow
// csr       in/out     psel penable pwrite     paddr, pwdata, prdata, pready
//
// a request writes the buffer and takes the magnitude, then squares and accumulates
// closing a group adds a bit-serial square root of the sum of squares
// each clipped element goes through memory read, multiply and a 24-step divider,
// an unclipped one skips the divider; the next element is prepared while a result waits
// synchronous active-high reset clears the group state; buffer contents stay undefined
// a stalled rsp holds the output register; new requests wait until the group is emitted
module group_l2_ball_projection_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [gblp_pkg::ElemW-1:0] req_elem_value,
   input  logic [gblp_pkg::GammaW-1:0]      req_group_weight,
   input  logic                             req_row_group,
   input  logic                             req_last_in_group,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [gblp_pkg::ElemW-1:0] rsp_scaled_value,
   output logic                             rsp_last_of_group,
   output logic                             rsp_was_clipped,
   output logic                             rsp_group_overflow,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [gblp_pkg::PaddrW-1:0]      paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);

   gblp_pkg::state_type state_ff, state_in;

   logic [gblp_pkg::GammaW-1:0]  gamma_col_ff, gamma_row_ff;
   logic [gblp_pkg::SumW-1:0]    sum_ff, sum_in;
   logic [gblp_pkg::CountW-1:0]  count_ff, count_in;
   logic                         ovf_ff, ovf_in;
   logic                         last_ff, last_in;
   logic                         stored_ff, stored_in;
   logic [gblp_pkg::ElemW-1:0]   mag_ff, mag_in;
   logic [2*gblp_pkg::GammaW-1:0] gw_ff, gw_in;
   logic [gblp_pkg::NormW-1:0]   norm_ff, norm_in;
   logic                         clip_ff, clip_in;
   logic [gblp_pkg::CountW-1:0]  idx_ff, idx_in;
   logic                         neg_ff, neg_in;
   logic [gblp_pkg::ElemW-1:0]   res_ff, res_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [gblp_pkg::ElemW-1:0]   rsp_value_ff, rsp_value_in;
   logic                         rsp_last_ff, rsp_last_in;
   logic                         rsp_clip_ff, rsp_clip_in;
   logic                         rsp_ovf_ff, rsp_ovf_in;

   logic                         req_acc;
   logic                         wr_en;
   logic [gblp_pkg::ElemW-1:0]   rd_data;
   logic [gblp_pkg::ElemW-1:0]   rd_mag;
   logic [gblp_pkg::DvdW-1:0]    prod;
   logic [gblp_pkg::RadiusW-1:0] radius;
   logic [gblp_pkg::NormW-1:0]   root;
   logic [gblp_pkg::QuoW-1:0]    quotient;
   logic                         cfg_wr;
   gblp_pkg::unit_ctl_type       sqrt_ctl, div_ctl;

   // configuration registers
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_col_ff <= gblp_pkg::GammaReset;
         gamma_row_ff <= gblp_pkg::GammaReset;
      end else if (cfg_wr) begin
         case (paddr[2])
            gblp_pkg::RegGammaColumn: gamma_col_ff <= pwdata[gblp_pkg::GammaW-1:0];
            gblp_pkg::RegGammaRow:    gamma_row_ff <= pwdata[gblp_pkg::GammaW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         gblp_pkg::RegGammaColumn: prdata = {8'd0, gamma_col_ff};
         gblp_pkg::RegGammaRow:    prdata = {8'd0, gamma_row_ff};
         default:                  prdata = '0;
      endcase
   end

   // element buffer
   assign req_ready = (state_ff == gblp_pkg::ST_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign wr_en     = req_acc && (count_ff < gblp_pkg::CountW'(gblp_pkg::MaxGroupLen));

   gblp_ram #(
      .Width (gblp_pkg::ElemW),
      .Depth (gblp_pkg::MaxGroupLen)
   ) u_buf (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[gblp_pkg::AddrW-1:0]),
      .wr_data (req_elem_value),
      .rd_addr (idx_ff[gblp_pkg::AddrW-1:0]),
      .rd_data (rd_data)
   );

   // norm and per-element divide units
   assign sqrt_ctl.start = (state_ff == gblp_pkg::ST_ROOT_GO);
   assign div_ctl.start  = (state_ff == gblp_pkg::ST_MUL) && clip_ff;

   gblp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_ctl.start),
      .radicand (sum_ff),
      .done     (sqrt_ctl.done),
      .root     (root)
   );

   gblp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_ctl.start),
      .dividend (prod),
      .divisor  (norm_ff),
      .done     (div_ctl.done),
      .quotient (quotient)
   );

   assign radius = gw_ff[2*gblp_pkg::GammaW-1 -: gblp_pkg::RadiusW];
   assign rd_mag = rd_data[gblp_pkg::ElemW-1] ? (~rd_data + 1'b1) : rd_data;

   // magnitude times radius, loaded into the divider as it starts
   assign prod = gblp_pkg::DvdW'(rd_mag) * gblp_pkg::DvdW'(radius[gblp_pkg::NormW-1:0]);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;
      stored_in    = stored_ff;
      mag_in       = mag_ff;
      gw_in        = gw_ff;
      norm_in      = norm_ff;
      clip_in      = clip_ff;
      idx_in       = idx_ff;
      neg_in       = neg_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_clip_in  = rsp_clip_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      case (state_ff)
         gblp_pkg::ST_IDLE: begin
            if (req_acc) begin
               stored_in = wr_en;
               mag_in    = req_elem_value[gblp_pkg::ElemW-1] ?
                           (~req_elem_value + 1'b1) : req_elem_value;
               last_in   = req_last_in_group;
               gw_in     = (req_row_group ? gamma_row_ff : gamma_col_ff) * req_group_weight;
               if (wr_en) begin
                  count_in = count_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = gblp_pkg::ST_ACC;
            end
         end
         gblp_pkg::ST_ACC: begin
            if (stored_ff) begin
               sum_in = sum_ff + gblp_pkg::SumW'(mag_ff) * gblp_pkg::SumW'(mag_ff);
            end
            state_in = last_ff ? gblp_pkg::ST_ROOT_GO : gblp_pkg::ST_IDLE;
         end
         gblp_pkg::ST_ROOT_GO: begin
            state_in = gblp_pkg::ST_ROOT;
         end
         gblp_pkg::ST_ROOT: begin
            if (sqrt_ctl.done) begin
               norm_in  = root;
               clip_in  = radius < gblp_pkg::RadiusW'(root);
               idx_in   = '0;
               state_in = gblp_pkg::ST_READ;
            end
         end
         gblp_pkg::ST_READ: begin
            state_in = gblp_pkg::ST_MUL;
         end
         gblp_pkg::ST_MUL: begin
            neg_in  = rd_data[gblp_pkg::ElemW-1];
            res_in  = rd_data;
            state_in = clip_ff ? gblp_pkg::ST_DIV : gblp_pkg::ST_EMIT;
         end
         gblp_pkg::ST_DIV: begin
            if (div_ctl.done) begin
               res_in   = neg_ff ? (~quotient + 1'b1) : quotient;
               state_in = gblp_pkg::ST_EMIT;
            end
         end
         gblp_pkg::ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               rsp_last_in  = (idx_ff + 1'b1 == count_ff);
               rsp_clip_in  = clip_ff;
               rsp_ovf_in   = ovf_ff;
               idx_in       = idx_ff + 1'b1;
               if (idx_ff + 1'b1 == count_ff) begin
                  sum_in   = '0;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  last_in  = 1'b0;
                  state_in = gblp_pkg::ST_IDLE;
               end else begin
                  state_in = gblp_pkg::ST_READ;
               end
            end
         end
         default: state_in = gblp_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gblp_pkg::ST_IDLE;
         sum_ff       <= '0;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      stored_ff    <= stored_in;
      mag_ff       <= mag_in;
      gw_ff        <= gw_in;
      norm_ff      <= norm_in;
      clip_ff      <= clip_in;
      idx_ff       <= idx_in;
      neg_ff       <= neg_in;
      res_ff       <= res_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_clip_ff  <= rsp_clip_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_scaled_value   = rsp_value_ff;
   assign rsp_last_of_group  = rsp_last_ff;
   assign rsp_was_clipped    = rsp_clip_ff;
   assign rsp_group_overflow = rsp_ovf_ff;

endmodule

// File: rtl/gblp_checker.sv
module gblp_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic signed [gblp_pkg::ElemW-1:0] rsp_scaled_value,
   input logic                             psel,
   input logic                             penable,
   input logic                             pwrite,
   input logic [gblp_pkg::PaddrW-1:0]      paddr,
   input logic [31:0]                      pwdata,
   input logic [31:0]                      prdata,
   input logic                             pready
);

   // a request is always followed by its accumulation before the next one is taken
   a_req_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on back-to-back cycles");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_scaled_value))
      else $error("stalled result changed");

   // no result straight out of reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // register readback after a write at the same address
   a_cfg_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready |=>
         (paddr != $past(paddr) || prdata[23:0] == $past(pwdata[23:0])))
      else $error("register readback mismatch");

endmodule

bind group_l2_ball_projection_top gblp_checker u_gblp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_scaled_value (rsp_scaled_value),
   .psel             (psel),
   .penable          (penable),
   .pwrite           (pwrite),
   .paddr            (paddr),
   .pwdata           (pwdata),
   .prdata           (prdata),
   .pready           (pready)
);

// File: dv/group_l2_ball_projection_top_test.sv
`timescale 1ns / 100ps

module group_l2_ball_projection_top_test;

   // expected projected element
   typedef struct {
      logic signed [gblp_pkg::ElemW-1:0] scaled;
      logic                              last;
      logic                              clipped;
      logic                              ovf;
   } proj_elem_type;

   // group projection predictor and expected-element store
   class projection_board_type;
      logic [gblp_pkg::GammaW-1:0]       gamma_col;
      logic [gblp_pkg::GammaW-1:0]       gamma_rw;
      logic signed [gblp_pkg::ElemW-1:0] elems[$];
      logic [63:0]                       sq_sum;
      bit                                dropped;
      proj_elem_type                     pending[$];
      int                                errors;

      function void clear_group();
         elems.delete();
         sq_sum  = 0;
         dropped = 0;
      endfunction

      function void set_gamma(bit row, logic [gblp_pkg::GammaW-1:0] v);
         if (row) begin
            gamma_rw = v;
         end else begin
            gamma_col = v;
         end
      endfunction

      function logic [63:0] int_sqrt(logic [63:0] v);
         logic [63:0] root;
         logic [63:0] b;
         root = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (v >= root + b) begin
               v = v - (root + b);
               root = (root >> 1) + b;
            end else begin
               root = root >> 1;
            end
            b = b >> 2;
         end
         return root;
      endfunction

      // note an accepted request; on the closing one predict the group output
      function void note_request(logic signed [gblp_pkg::ElemW-1:0] x,
                                 logic [gblp_pkg::GammaW-1:0] w, bit row, bit last);
         logic [63:0]   mag;
         logic [63:0]   radius;
         logic [63:0]   nrm;
         logic [63:0]   q;
         bit            clip;
         proj_elem_type p;
         if (elems.size() < gblp_pkg::MaxGroupLen) begin
            mag = (x < 0) ? 64'(-64'sd1 * 64'(signed'(x))) : 64'(x);
            elems.push_back(x);
            sq_sum += mag * mag;
         end else begin
            dropped = 1;
         end
         if (!last) return;
         radius = (64'(row ? gamma_rw : gamma_col) * 64'(w)) >> 16;
         nrm    = int_sqrt(sq_sum);
         clip   = radius < nrm;
         foreach (elems[k]) begin
            p.scaled = elems[k];
            if (clip) begin
               mag = (elems[k] < 0) ? 64'(-64'sd1 * 64'(signed'(elems[k])))
                                    : 64'(elems[k]);
               q = (mag * radius) / nrm;
               p.scaled = (elems[k] < 0) ? gblp_pkg::ElemW'(-q) : gblp_pkg::ElemW'(q);
            end
            p.last    = (k == elems.size() - 1);
            p.clipped = clip;
            p.ovf     = dropped;
            pending.push_back(p);
         end
         clear_group();
      endfunction

      function void check_result(logic signed [gblp_pkg::ElemW-1:0] v, bit l, bit c, bit o);
         proj_elem_type e;
         if (pending.size() == 0) begin
            $error("unexpected result scaled_value=%0d", v);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (v !== e.scaled) begin
            $error("scaled_value exp %0d got %0d", e.scaled, v); errors++;
         end
         if (l !== e.last) begin
            $error("last_of_group exp %0b got %0b", e.last, l); errors++;
         end
         if (c !== e.clipped) begin
            $error("was_clipped exp %0b got %0b", e.clipped, c); errors++;
         end
         if (o !== e.ovf) begin
            $error("group_overflow exp %0b got %0b", e.ovf, o); errors++;
         end
      endfunction
   endclass

   logic                              clock = 0;
   logic                              reset = 1;
   logic                              req_valid = 0;
   logic                              req_ready;
   logic signed [gblp_pkg::ElemW-1:0] req_elem_value = 0;
   logic [gblp_pkg::GammaW-1:0]       req_group_weight = 0;
   logic                              req_row_group = 0;
   logic                              req_last_in_group = 0;
   logic                              rsp_valid;
   logic                              rsp_ready = 0;
   logic signed [gblp_pkg::ElemW-1:0] rsp_scaled_value;
   logic                              rsp_last_of_group;
   logic                              rsp_was_clipped;
   logic                              rsp_group_overflow;
   logic                              psel = 0;
   logic                              penable = 0;
   logic                              pwrite = 0;
   logic [gblp_pkg::PaddrW-1:0]       paddr = 0;
   logic [31:0]                       pwdata = 0;
   logic [31:0]                       prdata;
   logic                              pready;

   projection_board_type board;

   group_l2_ball_projection_top u_dut (.*);

   always #5 clock = ~clock;

   // run limit
   initial begin
      #50ms;
      $display("status: fail");
      $finish;
   end

   // apb register write
   task automatic write_gamma(bit row, logic [gblp_pkg::GammaW-1:0] v);
      @(negedge clock);
      psel   <= 1;
      pwrite <= 1;
      paddr  <= gblp_pkg::PaddrW'(row ? 4 : 0);
      pwdata <= 32'(v);
      @(negedge clock);
      penable <= 1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      board.set_gamma(row, v);
      @(negedge clock);
      psel    <= 0;
      penable <= 0;
      pwrite  <= 0;
   endtask

   // send one request, with a random gap before it when gaps is set
   task automatic send_request(logic signed [gblp_pkg::ElemW-1:0] x,
                               logic [gblp_pkg::GammaW-1:0] w,
                               bit row, bit last, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 12) : 0;
      @(negedge clock);
      repeat (gap) @(negedge clock);
      req_valid         <= 1;
      req_elem_value    <= x;
      req_group_weight  <= w;
      req_row_group     <= row;
      req_last_in_group <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(x, w, row, last);
      @(negedge clock);
      req_valid <= 0;
   endtask

   function automatic logic signed [gblp_pkg::ElemW-1:0] rand_elem(int mode);
      case (mode)
         0: return gblp_pkg::ElemW'($urandom);
         1: return gblp_pkg::ElemW'($signed($urandom_range(0, 2000)) - 1000);
         default: return gblp_pkg::ElemW'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
      endcase
   endfunction

   // send a group of given length
   task automatic send_group(int len, logic [gblp_pkg::GammaW-1:0] w, bit row, int mode);
      for (int i = 0; i < len; i++)
         send_request(rand_elem(mode), w, row, i == len - 1, 1);
   endtask

   task automatic wait_idle();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   // result sink with random stalls
   initial begin
      int stall;
      forever begin
         @(negedge clock);
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
         rsp_ready <= 0;
         repeat (stall) @(negedge clock);
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_result(rsp_scaled_value, rsp_last_of_group,
                            rsp_was_clipped, rsp_group_overflow);
      end
   end

   // stimulus
   initial begin
      int n;
      board = new();
      board.gamma_col = gblp_pkg::GammaReset;
      board.gamma_rw  = gblp_pkg::GammaReset;
      board.clear_group();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, zero norm, equal radius, clipping, zero radius
      send_request(24'sh7FFFFF, 24'hFFFFFF, 0, 0, 0);
      send_request(-24'sh800000, 24'hFFFFFF, 0, 1, 0);
      send_request(0, 24'h000000, 1, 0, 0);
      send_request(0, 24'h000000, 1, 1, 0);
      send_request(24'sd3 <<< 16, 24'h010000, 0, 0, 0);
      send_request(24'sd4 <<< 16, 24'h050000, 0, 1, 0);
      send_request(-24'sd3 <<< 16, 24'h040000, 1, 0, 0);
      send_request(24'sd4 <<< 16, 24'h040000, 1, 1, 0);
      send_request(24'sd1000, 24'h000000, 0, 0, 0);
      send_request(-24'sd7, 24'h000000, 0, 1, 0);
      send_request(-24'sd1, 24'hAAAAAA, 1, 1, 0);
      wait_idle();

      write_gamma(0, 24'd0);
      write_gamma(1, 24'hFFFFFF);
      send_request(24'sd12345, 24'h123456, 0, 1, 0);
      send_request(-24'sd54321, 24'h555555, 1, 1, 0);
      // buffer overflow with a dropped last item
      send_group(gblp_pkg::MaxGroupLen + 2, 24'h008000, 1, 2);
      wait_idle();

      // random phases with varied gamma
      for (int ph = 0; ph < 4; ph++) begin
         write_gamma(0, ph == 0 ? 24'hFFFFFF : 24'($urandom));
         write_gamma(1, ph == 3 ? 24'd0 : 24'($urandom_range(0, 24'h40000)));
         n = 0;
         while (n < 8) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20)
                                              : $urandom_range(1, 5);
            send_group(len, ($urandom_range(0, 1) ? 24'($urandom)
                                                  : 24'($urandom_range(0, 24'h30000))),
                       $urandom_range(0, 1), $urandom_range(0, 2));
            n += len;
         end
         wait_idle();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

// File: group_l2_ball_projection_top.f
rtl/gblp_pkg.sv
rtl/gblp_ram.sv
rtl/gblp_sqrt.sv
rtl/gblp_div.sv
rtl/group_l2_ball_projection_top.sv
rtl/gblp_checker.sv
dv/group_l2_ball_projection_top_test.sv
